FILE: sv/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;
	localparam logic signed [DATA_W-1:0] PUSH_VALUE  = '0;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_REAR  = 2'd1,
		FN_POP_FRONT  = 2'd2,
		FN_POP_REAR   = 2'd3
	} func_t;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

endpackage

`default_nettype wire

FILE: sv/deq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: one queue operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [deq_pkg::FUNC_W-1:0]            func;
	logic signed [deq_pkg::DATA_W-1:0]     push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink   (input valid, input func, input push_value, output ready);
endinterface

`default_nettype wire

FILE: sv/deq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [deq_pkg::DATA_W-1:0]     pop_value;
	logic [deq_pkg::STATUS_W-1:0]          status;
	logic [deq_pkg::OCC_W-1:0]             occupancy;

	modport source (output valid, output pop_value, output status, output occupancy,
		input ready);
	modport sink   (input valid, input pop_value, input status, input occupancy,
		output ready);
endinterface

`default_nettype wire

FILE: sv/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
	parameter int WIDTH = deq_pkg::DATA_W,
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a ring in one RAM.
//
// req carries one operation per transaction (push front, push rear,
// pop front, pop rear) with the value to push. rsp returns exactly one
// transaction per request, in order: the popped value, a status (done,
// pop on empty, push on full dropped) and the occupancy after the
// operation, taken modulo 32.
// Pushes and pops on an empty deque answer in the cycle after acceptance
// and a new request may be taken every cycle while rsp takes each result.
// A pop that finds an entry reads the RAM and answers from the RAM's read
// register through the output register; no request is taken during that
// read, so a pop is through before the next request is taken.
// The result sits in an output register; outside a RAM read a request is
// accepted while it is empty or being taken. When rsp stalls, req stalls too.
// Reset empties the deque at once (head and count cleared); the RAM
// contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

	deq_pkg::state_t state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic                              out_valid_q;
	logic signed [deq_pkg::DATA_W-1:0] pop_value_q;
	logic [deq_pkg::STATUS_W-1:0]      status_q;

	logic accept;
	logic is_full;
	logic is_empty;
	logic [deq_pkg::DATA_W-1:0] rdata;

	logic          we;
	logic [AW-1:0] waddr;
	logic          re;
	logic [AW-1:0] raddr;

	logic [AW-1:0] head_prev;
	logic [AW-1:0] head_next;
	logic [SW-1:0] rear_sum;
	logic [SW-1:0] last_sum;
	logic [AW-1:0] tail_slot;
	logic [AW-1:0] rear_slot;

	logic [AW-1:0]            head_d;
	logic [CW-1:0]            count_d;
	logic [CW+deq_pkg::OCC_W-1:0] occ_ext;

	assign req.ready = (state_q == deq_pkg::S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == FULL_CNT);
	assign is_empty  = (count_q == '0);

	// ring slot arithmetic
	assign head_prev = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
	assign rear_sum  = SW'(head_q) + SW'(count_q);
	assign tail_slot = (rear_sum >= DEPTH_S) ? AW'(rear_sum - DEPTH_S) : AW'(rear_sum);
	assign last_sum  = rear_sum - SW'(1);
	assign rear_slot = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

	always_comb begin
		we      = 1'b0;
		waddr   = tail_slot;
		re      = 1'b0;
		raddr   = head_q;
		head_d  = head_q;
		count_d = count_q;
		if (accept) begin
			case (deq_pkg::func_t'(req.func))
				deq_pkg::FN_PUSH_FRONT: begin
					if (!is_full) begin
						we      = 1'b1;
						waddr   = head_prev;
						head_d  = head_prev;
						count_d = count_q + CW'(1);
					end
				end
				deq_pkg::FN_PUSH_REAR: begin
					if (!is_full) begin
						we      = 1'b1;
						waddr   = tail_slot;
						count_d = count_q + CW'(1);
					end
				end
				deq_pkg::FN_POP_FRONT: begin
					if (!is_empty) begin
						re      = 1'b1;
						raddr   = head_q;
						head_d  = head_next;
						count_d = count_q - CW'(1);
					end
				end
				deq_pkg::FN_POP_REAR: begin
					if (!is_empty) begin
						re      = 1'b1;
						raddr   = rear_slot;
						count_d = count_q - CW'(1);
					end
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	deq_ram #(
		.WIDTH (deq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req.push_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			case (state_q)
				deq_pkg::S_IDLE: begin
					if (accept) begin
						if (re) begin
							state_q     <= deq_pkg::S_READ;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				deq_pkg::S_READ: begin
					state_q     <= deq_pkg::S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q     <= deq_pkg::S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == deq_pkg::S_READ) begin
			pop_value_q <= rdata;
			status_q    <= deq_pkg::ST_DONE;
		end else if (accept && !re) begin
			if (req.func[1]) begin
				pop_value_q <= deq_pkg::EMPTY_VALUE;
				status_q    <= deq_pkg::ST_EMPTY;
			end else begin
				pop_value_q <= deq_pkg::PUSH_VALUE;
				status_q    <= is_full ? deq_pkg::ST_FULL : deq_pkg::ST_DONE;
			end
		end
	end

	assign occ_ext       = {{deq_pkg::OCC_W{1'b0}}, count_q};
	assign rsp.valid     = out_valid_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occ_ext[deq_pkg::OCC_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == deq_pkg::S_READ) |-> !req.ready)
		else $error("request taken during ram read");

	a_pop_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func[1] && !is_empty) |=> (state_q == deq_pkg::S_READ))
		else $error("pop with entries did not read ram");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == deq_pkg::ST_FULL) |-> is_full)
		else $error("full status while not full");

	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re))
		else $error("ram written and read in one cycle");

endmodule

`default_nettype wire

FILE: tb/sv/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded deque. A driver sends a directed
// opening (empty pops, extreme values, filling to full, pushes on full)
// and then biased random bursts that swing the deque between empty and
// full. Every request transaction is predicted by a shadow ring and each
// response transaction is checked field by field, in order. Both channels
// idle at random; the receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RAND_ITEMS  = 1300;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		func_t                    func;
		logic signed [DATA_W-1:0] value;
		bit                       no_gap;
		bit                       drain;
	} deq_op_t;

	typedef struct {
		logic signed [DATA_W-1:0] pop_value;
		logic [STATUS_W-1:0]      status;
		logic [OCC_W-1:0]         occupancy;
	} deq_result_t;

	logic clk = 1'b0;
	logic arst_n;

	deq_req_if req_if();
	deq_rsp_if rsp_if();

	double_ended_queue #(.DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #1 clk = ~clk;

	deq_op_t     pending_ops[$];
	deq_result_t expected_results[$];

	logic signed [DATA_W-1:0] shadow_entries [DEPTH];
	int shadow_head  = 0;
	int shadow_count = 0;

	int issued       = 0;
	int accepted     = 0;
	int results_seen = 0;
	int errors       = 0;
	int n_done       = 0;
	int n_empty      = 0;
	int n_full       = 0;
	int peak_occ     = 0;
	int cycle_count  = 0;

	int tx_gap       = 0;
	int rx_stall     = 0;
	int rx_holds     = 0;
	int rx_hold_at   = 150;
	int rx_cycles    = 0;
	bit rx_holding   = 1'b0;
	bit rx_quiet     = 1'b0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		if ($urandom_range(0, 9) != 0)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			default: return -32'sd1;
		endcase
	endfunction

	function automatic deq_result_t deque_apply(func_t fn, logic signed [DATA_W-1:0] v);
		deq_result_t r;
		r.pop_value = PUSH_VALUE;
		r.status    = ST_DONE;
		case (fn)
			FN_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_entries[shadow_head] = v;
					shadow_count++;
				end
			end
			FN_PUSH_REAR: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_entries[(shadow_head + shadow_count) % DEPTH] = v;
					shadow_count++;
				end
			end
			FN_POP_FRONT: begin
				if (shadow_count == 0) begin
					r.pop_value = EMPTY_VALUE;
					r.status    = ST_EMPTY;
				end else begin
					r.pop_value = shadow_entries[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.pop_value = EMPTY_VALUE;
					r.status    = ST_EMPTY;
				end else begin
					r.pop_value = shadow_entries[(shadow_head + shadow_count - 1) % DEPTH];
					shadow_count--;
				end
			end
		endcase
		r.occupancy = shadow_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic add_op(func_t fn, logic signed [DATA_W-1:0] v, bit no_gap);
		deq_op_t op;
		op.func   = fn;
		op.value  = v;
		op.no_gap = no_gap;
		op.drain  = 1'b0;
		pending_ops.push_back(op);
	endtask

	task automatic add_drain();
		deq_op_t op;
		op.func   = FN_PUSH_FRONT;
		op.value  = '0;
		op.no_gap = 1'b0;
		op.drain  = 1'b1;
		pending_ops.push_back(op);
	endtask

	// request driver
	always @(negedge clk) begin
		deq_op_t op;
		if (arst_n) begin
			if (req_if.valid && issued != accepted) begin
			end else if (tx_gap > 0) begin
				req_if.valid <= 1'b0;
				tx_gap = tx_gap - 1;
			end else begin
				while (pending_ops.size() > 0 && pending_ops[0].drain
						&& expected_results.size() == 0 && issued == accepted)
					void'(pending_ops.pop_front());
				if (pending_ops.size() > 0 && !pending_ops[0].drain) begin
					op = pending_ops.pop_front();
					req_if.valid      <= 1'b1;
					req_if.func       <= op.func;
					req_if.push_value <= op.value;
					issued++;
					tx_gap = (op.no_gap || rx_holding) ? 0 : gap_len();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// response ready with random stalls and long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			rx_cycles++;
			if (rx_cycles % 128 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			if (rx_stall > 0) begin
				rsp_if.ready <= 1'b0;
				rx_stall--;
				if (rx_stall == 0)
					rx_holding = 1'b0;
			end else if (rx_holds < 2 && results_seen >= rx_hold_at) begin
				rsp_if.ready <= 1'b0;
				rx_stall   = LONG_HOLD;
				rx_holding = 1'b1;
				rx_holds++;
				rx_hold_at += 500;
			end else begin
				rsp_if.ready <= 1'b1;
				if (!rx_quiet && $urandom_range(0, 3) == 0)
					rx_stall = gap_len();
			end
		end
	end

	// prediction on request transactions, checking on response transactions
	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				accepted++;
				expected_results.push_back(deque_apply(func_t'(req_if.func), req_if.push_value));
			end
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result pop_value %0d status %0d occupancy %0d",
						$time, rsp_if.pop_value, rsp_if.status, rsp_if.occupancy);
				end else begin
					want = expected_results.pop_front();
					if (rsp_if.pop_value !== want.pop_value) begin
						errors++;
						$display("%0t: pop_value expected %0d actual %0d",
							$time, want.pop_value, rsp_if.pop_value);
					end
					if (rsp_if.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp_if.status);
					end
					if (rsp_if.occupancy !== want.occupancy) begin
						errors++;
						$display("%0t: occupancy expected %0d actual %0d",
							$time, want.occupancy, rsp_if.occupancy);
					end
					case (want.status)
						ST_EMPTY: n_empty++;
						ST_FULL:  n_full++;
						default:  n_done++;
					endcase
					if (want.occupancy > peak_occ)
						peak_occ = want.occupancy;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int n_rand;
		int seg_len;
		int push_pct;
		int segs;
		bit quiet;
		func_t fn;

		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.func       = FN_PUSH_FRONT;
		req_if.push_value = '0;
		rsp_if.ready      = 1'b0;

		// empty pops, extreme values, fill, pushes on full, pops at both ends
		add_op(FN_POP_FRONT, '0, 1'b0);
		add_op(FN_POP_REAR, -32'sd1, 1'b0);
		add_op(FN_PUSH_FRONT, 32'sh7fffffff, 1'b0);
		add_op(FN_PUSH_REAR, 32'sh80000000, 1'b0);
		add_op(FN_PUSH_FRONT, -32'sd1, 1'b0);
		add_op(FN_PUSH_REAR, '0, 1'b0);
		for (int i = 0; i < DEPTH - 4; i++)
			add_op((i % 2) ? FN_PUSH_FRONT : FN_PUSH_REAR, $urandom, 1'b1);
		add_op(FN_PUSH_FRONT, 32'sh12345678, 1'b0);
		add_op(FN_PUSH_REAR, 32'sh7fffffff, 1'b0);
		add_op(FN_POP_FRONT, '0, 1'b0);
		add_op(FN_POP_REAR, '0, 1'b0);
		add_drain();

		// biased bursts so the deque swings between empty and full
		n_rand = 0;
		segs   = 0;
		while (n_rand < RAND_ITEMS) begin
			seg_len = $urandom_range(8, 48);
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 20;
				default: push_pct = 50;
			endcase
			quiet = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < seg_len; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					fn = func_t'($urandom_range(0, 1));
				else
					fn = func_t'($urandom_range(2, 3));
				add_op(fn, rand_value(), quiet);
				n_rand++;
			end
			segs++;
			if (segs % 8 == 0)
				add_drain();
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() > 0 || issued != accepted)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("checked %0d transactions: %0d done, %0d pops on empty, %0d pushes on full",
			results_seen, n_done, n_empty, n_full);
		$display("peak occupancy %0d of %0d, %0d long receiver hold-offs",
			peak_occ, DEPTH, rx_holds);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
